### hw/rtl/gsfp_pkg.sv
// Shared types and constants for the gas sensor frame parser.
package gsfp_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] READ_COMMAND = 8'h86;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_BAD_CMD  = 2'd2
  } status_t;

  // Completed frame as handed from the front end to the back end.
  typedef struct packed {
    logic        cmd_ok;
    logic [15:0] value;
    logic [7:0]  computed;
    logic [7:0]  received;
  } frame_t;

  // Result item as delivered on the output queue.
  typedef struct packed {
    status_t     status;
    logic [15:0] frame_value;
    logic [15:0] concentration_tenths;
    logic        reading_valid;
    logic [15:0] checksum_errors;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
  } result_t;

endpackage

### hw/rtl/gas_sensor_frame_parser.sv
// The last byte of a frame pushes the completed frame into the frame queue; the back end then
// takes it and pushes its result into the output queue; the result then shows on the ports.
// Throughput: one byte per cycle; each end takes one item per cycle unless its queue is full.
// Full rises only when the frame queue between front and back end is full.
// Reset (rst, synchronous): parser idles hunting for the start byte, reading and
// error counter clear, both queues empty.
module gas_sensor_frame_parser #(
  parameter int FRAME_LENGTH = 9,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst,
  // byte input, queue style
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  // result output, queue style
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  frame_status,
  output logic [15:0] frame_value,
  output logic [15:0] concentration_tenths,
  output logic        reading_valid,
  output logic [15:0] checksum_errors,
  output logic [7:0]  computed_sum,
  output logic [7:0]  received_sum
);

  localparam int FW = $bits(gsfp_pkg::frame_t);
  localparam int RW = $bits(gsfp_pkg::result_t);

  logic              in_accept;
  logic              frame_done;
  gsfp_pkg::frame_t  front_frame;
  logic              mid_full;
  logic              mid_empty;
  logic [FW-1:0]     mid_rdata;
  gsfp_pkg::frame_t  mid_frame;
  logic              frame_take;
  logic              out_full;
  logic              result_push;
  gsfp_pkg::result_t back_result;
  logic [RW-1:0]     out_rdata;
  gsfp_pkg::result_t out_result;

  // Accept a byte whenever the frame queue has room; only the last byte of a
  // frame pushes into it, so a stalled consumer throttles the input only once
  // completed frames pile up.
  assign full      = mid_full;
  assign in_accept = push && !full;

  // Front end: framing and running checksum.
  gsfp_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .rx_byte    (rx_byte),
    .frame_done (frame_done),
    .frame      (front_frame)
  );

  // Decoupling queue of completed frames.
  gsfp_fifo #(
    .WIDTH(FW),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (frame_done),
    .wdata (FW'(front_frame)),
    .full  (mid_full),
    .pop   (frame_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_frame = gsfp_pkg::frame_t'(mid_rdata);

  // Back end: verdict, last good reading, error counter.
  gsfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_ready (!mid_empty),
    .frame       (mid_frame),
    .frame_take  (frame_take),
    .result_full (out_full),
    .result_push (result_push),
    .result      (back_result)
  );

  // Output queue: hold results while the consumer stalls.
  gsfp_fifo #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (result_push),
    .wdata (RW'(back_result)),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_result           = gsfp_pkg::result_t'(out_rdata);
  assign frame_status         = 2'(out_result.status);
  assign frame_value          = out_result.frame_value;
  assign concentration_tenths = out_result.concentration_tenths;
  assign reading_valid        = out_result.reading_valid;
  assign checksum_errors      = out_result.checksum_errors;
  assign computed_sum         = out_result.computed_sum;
  assign received_sum         = out_result.received_sum;

  // A frame completes only on an accepted byte.
  a_frame_on_accept: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> in_accept)
    else $error("frame completed without an accepted byte");

  // A passing frame becomes the current reading.
  a_ok_updates_reading: assert property (@(posedge clk) disable iff (rst)
    (result_push && back_result.status == gsfp_pkg::STATUS_OK) |->
      (back_result.reading_valid &&
       back_result.concentration_tenths == back_result.frame_value))
    else $error("accepted frame did not update the reading");

  // A checksum failure clears valid and bumps the counter by one.
  a_mismatch_counts: assert property (@(posedge clk) disable iff (rst)
    (result_push && back_result.status == gsfp_pkg::STATUS_MISMATCH) |=>
      (!u_back.valid_flag &&
       u_back.err_count == $past(back_result.checksum_errors)))
    else $error("checksum failure not recorded");

endmodule

### hw/rtl/gsfp_fifo.sv
// Small synchronous queue with first-word fall-through read.
module gsfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/gsfp_front.sv
// Front end: byte framing, field capture and running checksum.
module gsfp_front #(
  parameter int FRAME_LENGTH = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  output logic              frame_done,
  output gsfp_pkg::frame_t  frame
);

  localparam int PW = $clog2(FRAME_LENGTH + 1);
  localparam logic [PW-1:0] IDLE_POS = PW'(FRAME_LENGTH);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LENGTH - 1);
  localparam logic [PW-1:0] SUM_END  = PW'(FRAME_LENGTH - 2);
  localparam logic [PW-1:0] POS_CMD  = PW'(1);
  localparam logic [PW-1:0] POS_HIGH = PW'(2);
  localparam logic [PW-1:0] POS_LOW  = PW'(3);

  logic [PW-1:0] pos;
  logic [7:0]    running_sum;
  logic [7:0]    command_byte;
  logic [7:0]    value_high;
  logic [7:0]    value_low;
  logic          idle;

  assign idle       = (pos >= IDLE_POS);
  assign frame_done = accept && !idle && (pos == LAST_POS);

  assign frame.cmd_ok   = (command_byte == gsfp_pkg::READ_COMMAND);
  assign frame.value    = {value_high, value_low};
  assign frame.computed = 8'(8'd0 - running_sum);
  assign frame.received = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= IDLE_POS;
      running_sum  <= '0;
      command_byte <= '0;
      value_high   <= '0;
      value_low    <= '0;
    end else if (accept) begin
      if (idle) begin
        // hunt for the start byte, drop everything else
        if (rx_byte == gsfp_pkg::START_BYTE) begin
          pos         <= POS_CMD;
          running_sum <= '0;
        end
      end else begin
        if (pos == POS_CMD) begin
          command_byte <= rx_byte;
        end
        if (pos == POS_HIGH) begin
          value_high <= rx_byte;
        end
        if (pos == POS_LOW) begin
          value_low <= rx_byte;
        end
        if (pos <= SUM_END) begin
          running_sum <= running_sum + rx_byte;
        end
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

### hw/rtl/gsfp_back.sv
// Back end: frame verdict, reading state and error counter.
module gsfp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_ready,
  input  gsfp_pkg::frame_t  frame,
  output logic              frame_take,
  input  logic              result_full,
  output logic              result_push,
  output gsfp_pkg::result_t result
);

  logic [15:0]       last_good;
  logic              valid_flag;
  logic [15:0]       err_count;
  logic [15:0]       last_good_next;
  logic              valid_flag_next;
  logic [15:0]       err_count_next;
  gsfp_pkg::status_t status;

  assign frame_take  = frame_ready && !result_full;
  assign result_push = frame_take;

  always_comb begin
    last_good_next  = last_good;
    valid_flag_next = valid_flag;
    err_count_next  = err_count;
    if (!frame.cmd_ok) begin
      status = gsfp_pkg::STATUS_BAD_CMD;
    end else if (frame.computed != frame.received) begin
      status          = gsfp_pkg::STATUS_MISMATCH;
      err_count_next  = err_count + 16'd1;
      valid_flag_next = 1'b0;
    end else begin
      status          = gsfp_pkg::STATUS_OK;
      last_good_next  = frame.value;
      valid_flag_next = 1'b1;
    end
  end

  assign result.status               = status;
  assign result.frame_value          = frame.value;
  assign result.concentration_tenths = last_good_next;
  assign result.reading_valid        = valid_flag_next;
  assign result.checksum_errors      = err_count_next;
  assign result.computed_sum         = frame.computed;
  assign result.received_sum         = frame.received;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_good  <= '0;
      valid_flag <= 1'b0;
      err_count  <= '0;
    end else if (frame_take) begin
      last_good  <= last_good_next;
      valid_flag <= valid_flag_next;
      err_count  <= err_count_next;
    end
  end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the gas sensor frame parser: byte stream in, frame results out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LEN    = 9;     // bytes per frame, start byte included
  localparam int RANDOM_BYTES = 1200;  // bytes to send in the random part
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 16;    // settle time after the last result

  logic        clk;
  logic        rst     = 1'b1;
  logic        push    = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop     = 1'b0;
  logic [1:0]  frame_status;
  logic [15:0] frame_value;
  logic [15:0] concentration_tenths;
  logic        reading_valid;
  logic [15:0] checksum_errors;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;

  gas_sensor_frame_parser #(
    .FRAME_LENGTH(FRAME_LEN)
  ) dut (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .rx_byte              (rx_byte),
    .empty                (empty),
    .pop                  (pop),
    .frame_status         (frame_status),
    .frame_value          (frame_value),
    .concentration_tenths (concentration_tenths),
    .reading_valid        (reading_valid),
    .checksum_errors      (checksum_errors),
    .computed_sum         (computed_sum),
    .received_sum         (received_sum)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: a private copy of the parser state, advanced once per
  // accepted byte. Every completed frame yields one expected result.
  // ---------------------------------------------------------------------------
  int unsigned frame_pos = FRAME_LEN;  // FRAME_LEN means hunting for the start byte
  logic [7:0]  frame_sum;
  logic [7:0]  cmd_seen;
  logic [7:0]  value_hi;
  logic [7:0]  value_lo;
  logic [15:0] held_reading;
  logic        held_valid;
  logic [15:0] sum_fail_count;

  gsfp_pkg::result_t pending_frames [$];  // expected results, oldest first

  // Idle and stall rates in percent, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  // Bookkeeping for the summary and the final verdict.
  int unsigned failures      = 0;
  int unsigned frame_bytes   = 0;  // bytes taken into frames, start bytes included
  int unsigned dropped_bytes = 0;  // bytes dropped while hunting
  int unsigned status_seen [3] = '{0, 0, 0};

  // Directed stimulus. The expected results of its three frames are typed in
  // and replace what the predictor would queue; the predictor still advances
  // its own state on these frames.
  localparam int DIR_LEN = 28;
  logic [7:0] dir_bytes [DIR_LEN] = '{
    // dropped while hunting: a command byte outside a frame
    8'h86,
    // all-zero payload, good checksum
    8'hFF, 8'h86, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7A,
    // all-ones payload with start bytes inside the frame, wrong checksum
    8'hFF, 8'h86, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    // start byte in the command slot: unsupported command, no resync
    8'hFF, 8'hFF, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'hBB
  };
  gsfp_pkg::result_t dir_results [3] = '{
    '{gsfp_pkg::STATUS_OK,       16'h0000, 16'h0000, 1'b1, 16'h0000, 8'h7A, 8'h7A},
    '{gsfp_pkg::STATUS_MISMATCH, 16'hFFFF, 16'h0000, 1'b0, 16'h0001, 8'h80, 8'h00},
    '{gsfp_pkg::STATUS_BAD_CMD,  16'h1234, 16'h0000, 1'b0, 16'h0001, 8'hBB, 8'hBB}
  };
  bit          use_dir_results = 1'b0;
  int unsigned dir_result_idx  = 0;

  // Advance the predictor by one accepted byte; queue a result when a frame closes.
  task automatic track_byte(input logic [7:0] b);
    gsfp_pkg::result_t res;
    logic [7:0]        negated;
    int unsigned       pos;
    pos = frame_pos;
    // Hunting: only the start byte opens a frame, everything else is dropped.
    if (pos >= FRAME_LEN) begin
      if (b == gsfp_pkg::START_BYTE) begin
        frame_pos   = 1;
        frame_sum   = 8'h00;
        frame_bytes++;
      end else begin
        dropped_bytes++;
      end
      return;
    end
    frame_bytes++;
    if (pos == 1) cmd_seen = b;
    if (pos == 2) value_hi = b;
    if (pos == 3) value_lo = b;
    if (pos <= FRAME_LEN - 2) frame_sum = frame_sum + b;
    frame_pos = pos + 1;
    if (pos != FRAME_LEN - 1) return;

    // Last byte is the checksum: compare against the negated running sum.
    negated = 8'h00 - frame_sum;
    if (cmd_seen != gsfp_pkg::READ_COMMAND) begin
      res.status = gsfp_pkg::STATUS_BAD_CMD;
    end else if (negated != b) begin
      res.status     = gsfp_pkg::STATUS_MISMATCH;
      sum_fail_count = sum_fail_count + 16'd1;
      held_valid     = 1'b0;
    end else begin
      res.status   = gsfp_pkg::STATUS_OK;
      held_reading = {value_hi, value_lo};
      held_valid   = 1'b1;
    end
    res.frame_value          = {value_hi, value_lo};
    res.concentration_tenths = held_reading;
    res.reading_valid        = held_valid;
    res.checksum_errors      = sum_fail_count;
    res.computed_sum         = negated;
    res.received_sum         = b;
    if (use_dir_results) begin
      res = dir_results[dir_result_idx];
      dir_result_idx++;
    end
    pending_frames.push_back(res);
  endtask

  // ---------------------------------------------------------------------------
  // Byte sender. Called and returns at a falling edge; idles at random first,
  // then holds the byte until the parser takes it.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    track_byte(b);
    @(negedge clk);
  endtask

  // Pick a payload byte, leaning on the extremes now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send one well-formed frame with random content; the command or the
  // checksum is corrupted now and then.
  task automatic send_random_frame();
    logic [7:0] body [FRAME_LEN];
    logic [7:0] sum;
    body[0] = gsfp_pkg::START_BYTE;
    body[1] = ($urandom_range(9) == 0) ? pick_byte() : gsfp_pkg::READ_COMMAND;
    sum     = 8'h00;
    for (int i = 2; i <= FRAME_LEN - 2; i++) body[i] = pick_byte();
    for (int i = 1; i <= FRAME_LEN - 2; i++) sum = sum + body[i];
    body[FRAME_LEN-1] = 8'h00 - sum;
    if ($urandom_range(4) == 0)
      body[FRAME_LEN-1] = body[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < FRAME_LEN; i++) send_byte(body[i]);
  endtask

  // Line noise between frames; a stray start byte now and then breaks the framing.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 5);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_byte(gsfp_pkg::START_BYTE);
      else send_byte(8'($urandom_range(254)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: drive pop at the falling edge, check at the rising edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= pop_stall_pct);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    gsfp_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (pending_frames.size() == 0) begin
        $error("result popped with no frame pending (status %0d, value 0x%0h)",
               frame_status, frame_value);
        failures++;
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_status", want.status, frame_status);
        check_field("frame_value", want.frame_value, frame_value);
        check_field("concentration_tenths", want.concentration_tenths,
                    concentration_tenths);
        check_field("reading_valid", want.reading_valid, reading_valid);
        check_field("checksum_errors", want.checksum_errors, checksum_errors);
        check_field("computed_sum", want.computed_sum, computed_sum);
        check_field("received_sum", want.received_sum, received_sum);
        if (want.status <= gsfp_pkg::STATUS_BAD_CMD) status_seen[want.status]++;
      end
    end
  end

  // Watchdog: end the run when neither side has moved an item for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("gas_sensor_frame_parser regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    // Mirror the reset state in the predictor.
    frame_pos      = FRAME_LEN;
    frame_sum      = 8'h00;
    cmd_seen       = 8'h00;
    value_hi       = 8'h00;
    value_lo       = 8'h00;
    held_reading   = 16'h0000;
    held_valid     = 1'b0;
    sum_fail_count = 16'h0000;

    // Hold reset, then release it at a falling edge.
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: walk the table with no idling on either side.
    use_dir_results = 1'b1;
    for (int i = 0; i < DIR_LEN; i++) send_byte(dir_bytes[i]);
    use_dir_results = 1'b0;

    // Random part: rotate through the idling phases, mostly whole frames.
    phase = 0;
    while (frame_bytes + dropped_bytes < DIR_LEN + RANDOM_BYTES) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 45; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 45; end
        default: begin send_idle_pct = 16; pop_stall_pct = 16; end
      endcase
      for (int k = 0; k < 15 && frame_bytes + dropped_bytes < DIR_LEN + RANDOM_BYTES;
           k++) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_random_frame();
      end
      phase++;
    end
    push <= 1'b0;

    // Drain: pop freely until every expected result is in, then settle.
    pop_stall_pct = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d frame bytes and %0d dropped noise bytes over %0d idling phases",
             frame_bytes, dropped_bytes, phase);
    $display("frames checked: %0d good, %0d checksum errors, %0d bad commands",
             status_seen[gsfp_pkg::STATUS_OK], status_seen[gsfp_pkg::STATUS_MISMATCH],
             status_seen[gsfp_pkg::STATUS_BAD_CMD]);
    if (failures == 0) begin
      $display("gas_sensor_frame_parser regression: pass");
    end else begin
      $display("gas_sensor_frame_parser regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/gsfp_pkg.sv
hw/rtl/gsfp_fifo.sv
hw/rtl/gsfp_front.sv
hw/rtl/gsfp_back.sv
hw/rtl/gas_sensor_frame_parser.sv
tb/sv/tb_top.sv
